// ----- design/pnn_pkg.sv -----
// shared types and constants for the polygon newell normal core
`default_nettype none
package pnn_pkg;

    localparam int ACC_W   = 40;
    localparam int IDX_W   = 16;
    localparam int NRM_W   = 16;
    localparam int QUO_W   = 15;
    localparam int ROOT_W  = 32;
    localparam int SUM_W   = 64;
    localparam int REM_W   = 48;
    localparam int FRAC_SH = 14;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_DEGEN = 2'd1,
        ST_LONG  = 2'd2
    } status_t;

    typedef struct packed {
        logic [ACC_W-1:0] acc_x;
        logic [ACC_W-1:0] acc_y;
        logic [ACC_W-1:0] acc_z;
        logic [IDX_W-1:0] index;
        status_t          status;
    } job_t;

    typedef struct packed {
        logic [NRM_W-1:0] normal_x;
        logic [NRM_W-1:0] normal_y;
        logic [NRM_W-1:0] normal_z;
        logic [IDX_W-1:0] target_index;
        status_t          status;
    } result_t;

endpackage
`default_nettype wire

// ----- design/pnn_front.sv -----
// vertex intake and newell sum accumulation
`default_nettype none
module pnn_front
    import pnn_pkg::*;
#(
    parameter int MAX_VERT = 16,
    parameter int COORD_W  = 16
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic signed [COORD_W-1:0] in_x,
    input  wire logic signed [COORD_W-1:0] in_y,
    input  wire logic signed [COORD_W-1:0] in_z,
    input  wire logic [IDX_W-1:0]          in_index,
    input  wire logic                      in_last,
    output logic                           push_valid,
    input  wire logic                      push_ready,
    output job_t                           push_job
);
    localparam int CNT_W = $clog2(MAX_VERT + 1);
    localparam int DW    = COORD_W + 1;
    localparam int PW    = (2 * DW > ACC_W) ? 2 * DW : ACC_W;

    typedef enum logic [1:0] {F_IDLE, F_MUL, F_ACC, F_PUSH} fstate_t;

    fstate_t                    state_reg;
    logic signed [COORD_W-1:0]  ea_reg    [3];
    logic signed [COORD_W-1:0]  eb_reg    [3];
    logic signed [COORD_W-1:0]  first_reg [3];
    logic signed [COORD_W-1:0]  prev_reg  [3];
    logic [IDX_W-1:0]           first_idx_reg;
    logic [ACC_W-1:0]           acc_reg   [3];
    logic [ACC_W-1:0]           prod_reg  [3];
    logic [CNT_W-1:0]           cnt_reg;
    logic                       ovf_reg;
    logic                       last_reg;
    logic                       close_reg;

    logic signed [DW-1:0] dif [3];
    logic signed [DW-1:0] sm  [3];
    logic signed [PW-1:0] pr  [3];
    logic                 acc_zero;

    assign in_ready   = (state_reg == F_IDLE);
    assign push_valid = (state_reg == F_PUSH);

    always_comb begin
        // edge a -> b: x uses y,z ; y uses z,x ; z uses x,y
        dif[0] = DW'(ea_reg[1]) - DW'(eb_reg[1]);
        sm[0]  = DW'(ea_reg[2]) + DW'(eb_reg[2]);
        dif[1] = DW'(ea_reg[2]) - DW'(eb_reg[2]);
        sm[1]  = DW'(ea_reg[0]) + DW'(eb_reg[0]);
        dif[2] = DW'(ea_reg[0]) - DW'(eb_reg[0]);
        sm[2]  = DW'(ea_reg[1]) + DW'(eb_reg[1]);
        for (int i = 0; i < 3; i++) begin
            pr[i] = PW'(dif[i]) * PW'(sm[i]);
        end
        acc_zero = (acc_reg[0] == '0) && (acc_reg[1] == '0) && (acc_reg[2] == '0);
        push_job.acc_x  = acc_reg[0];
        push_job.acc_y  = acc_reg[1];
        push_job.acc_z  = acc_reg[2];
        push_job.index  = first_idx_reg;
        push_job.status = ovf_reg ? ST_LONG : (acc_zero ? ST_DEGEN : ST_OK);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
            close_reg <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                acc_reg[i] <= '0;
            end
        end else begin
            case (state_reg)
                F_IDLE: begin
                    if (in_valid) begin
                        last_reg  <= in_last;
                        close_reg <= 1'b0;
                        eb_reg[0] <= in_x;
                        eb_reg[1] <= in_y;
                        eb_reg[2] <= in_z;
                        prev_reg[0] <= in_x;
                        prev_reg[1] <= in_y;
                        prev_reg[2] <= in_z;
                        if (cnt_reg == '0) begin
                            // first vertex: zero-length edge
                            ea_reg[0] <= in_x;
                            ea_reg[1] <= in_y;
                            ea_reg[2] <= in_z;
                            first_reg[0] <= in_x;
                            first_reg[1] <= in_y;
                            first_reg[2] <= in_z;
                            first_idx_reg <= in_index;
                            cnt_reg <= CNT_W'(1);
                        end else begin
                            for (int i = 0; i < 3; i++) begin
                                ea_reg[i] <= prev_reg[i];
                            end
                            if (cnt_reg >= CNT_W'(MAX_VERT)) begin
                                ovf_reg <= 1'b1;
                            end else begin
                                cnt_reg <= cnt_reg + CNT_W'(1);
                            end
                        end
                        state_reg <= F_MUL;
                    end
                end
                F_MUL: begin
                    for (int i = 0; i < 3; i++) begin
                        prod_reg[i] <= pr[i][ACC_W-1:0];
                    end
                    state_reg <= F_ACC;
                end
                F_ACC: begin
                    for (int i = 0; i < 3; i++) begin
                        acc_reg[i] <= acc_reg[i] + prod_reg[i];
                    end
                    if (last_reg && !close_reg) begin
                        // closing edge back to the first vertex
                        close_reg <= 1'b1;
                        for (int i = 0; i < 3; i++) begin
                            ea_reg[i] <= eb_reg[i];
                            eb_reg[i] <= first_reg[i];
                        end
                        state_reg <= F_MUL;
                    end else if (last_reg) begin
                        state_reg <= F_PUSH;
                    end else begin
                        state_reg <= F_IDLE;
                    end
                end
                F_PUSH: begin
                    if (push_ready) begin
                        for (int i = 0; i < 3; i++) begin
                            acc_reg[i] <= '0;
                        end
                        cnt_reg   <= '0;
                        ovf_reg   <= 1'b0;
                        state_reg <= F_IDLE;
                    end
                end
                default: state_reg <= F_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- design/pnn_queue.sv -----
// two-entry job queue between intake and normalizer
`default_nettype none
module pnn_queue
    import pnn_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push_valid,
    output logic      push_ready,
    input  wire job_t push_job,
    output logic      pop_valid,
    input  wire logic pop_ready,
    output job_t      pop_job
);
    job_t       slot_reg [2];
    logic       wr_reg;
    logic       rd_reg;
    logic [1:0] cnt_reg;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (cnt_reg != 2'd2);
    assign pop_valid  = (cnt_reg != 2'd0);
    assign pop_job    = slot_reg[rd_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_reg] <= push_job;
        end
        if (!aresetn) begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (do_push) begin
                wr_reg <= ~wr_reg;
            end
            if (do_pop) begin
                rd_reg <= ~rd_reg;
            end
            case ({do_push, do_pop})
                2'b10:   cnt_reg <= cnt_reg + 2'd1;
                2'b01:   cnt_reg <= cnt_reg - 2'd1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- design/pnn_back.sv -----
// normalizer: scale, sum of squares, bit-serial root and divide
`default_nettype none
module pnn_back
    import pnn_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic pop_valid,
    output logic      pop_ready,
    input  wire job_t pop_job,
    output logic      res_valid,
    input  wire logic res_ready,
    output result_t   res
);
    typedef enum logic [2:0] {
        B_IDLE, B_SHIFT, B_SQ, B_SQRT, B_DINIT, B_DIV, B_OUT
    } bstate_t;

    bstate_t           state_reg;
    logic [ACC_W-1:0]  mag_reg [3];
    logic              neg_reg [3];
    logic [NRM_W-1:0]  nrm_reg [3];
    logic [IDX_W-1:0]  idx_reg;
    status_t           status_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  x_reg;
    logic [SUM_W-1:0]  root_reg;
    logic [SUM_W-1:0]  bit_reg;
    logic [ROOT_W-1:0] q_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic [3:0]        step_reg;
    logic [1:0]        comp_reg;

    logic [ACC_W-1:0]  acc_in [3];
    logic [ACC_W-1:0]  orv;
    logic [30:0]       msel;
    logic [61:0]       sq;
    logic [SUM_W-1:0]  trial_root;
    logic [SUM_W-1:0]  root_next;
    logic [REM_W-1:0]  trial_div;
    logic [QUO_W-1:0]  quo_next;

    assign pop_ready = (state_reg == B_IDLE);
    assign res_valid = (state_reg == B_OUT);

    always_comb begin
        acc_in[0]  = pop_job.acc_x;
        acc_in[1]  = pop_job.acc_y;
        acc_in[2]  = pop_job.acc_z;
        orv        = mag_reg[0] | mag_reg[1] | mag_reg[2];
        msel       = mag_reg[comp_reg][30:0];
        sq         = 62'(msel) * 62'(msel);
        trial_root = root_reg + bit_reg;
        if (x_reg >= trial_root) begin
            root_next = (root_reg >> 1) + bit_reg;
        end else begin
            root_next = root_reg >> 1;
        end
        trial_div = REM_W'(q_reg) << step_reg;
        quo_next  = quo_reg;
        if (rem_reg >= trial_div) begin
            quo_next = quo_reg | (QUO_W'(1) << step_reg);
        end
        res.normal_x     = nrm_reg[0];
        res.normal_y     = nrm_reg[1];
        res.normal_z     = nrm_reg[2];
        res.target_index = idx_reg;
        res.status       = status_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
        end else begin
            case (state_reg)
                B_IDLE: begin
                    if (pop_valid) begin
                        idx_reg    <= pop_job.index;
                        status_reg <= pop_job.status;
                        sum_reg    <= '0;
                        comp_reg   <= 2'd0;
                        for (int i = 0; i < 3; i++) begin
                            neg_reg[i] <= acc_in[i][ACC_W-1];
                            mag_reg[i] <= acc_in[i][ACC_W-1] ? (~acc_in[i] + ACC_W'(1))
                                                             : acc_in[i];
                            nrm_reg[i] <= '0;
                        end
                        state_reg <= (pop_job.status == ST_OK) ? B_SHIFT : B_OUT;
                    end
                end
                B_SHIFT: begin
                    // bring the largest magnitude into [2^30, 2^31)
                    if (orv[ACC_W-1:31] != '0) begin
                        for (int i = 0; i < 3; i++) begin
                            mag_reg[i] <= mag_reg[i] >> 1;
                        end
                    end else if (!orv[30]) begin
                        for (int i = 0; i < 3; i++) begin
                            mag_reg[i] <= mag_reg[i] << 1;
                        end
                    end else begin
                        state_reg <= B_SQ;
                    end
                end
                B_SQ: begin
                    sum_reg <= sum_reg + SUM_W'(sq);
                    if (comp_reg == 2'd2) begin
                        x_reg     <= sum_reg + SUM_W'(sq);
                        root_reg  <= '0;
                        bit_reg   <= SUM_W'(1) << 62;
                        comp_reg  <= 2'd0;
                        state_reg <= B_SQRT;
                    end else begin
                        comp_reg <= comp_reg + 2'd1;
                    end
                end
                B_SQRT: begin
                    if (x_reg >= trial_root) begin
                        x_reg <= x_reg - trial_root;
                    end
                    root_reg <= root_next;
                    bit_reg  <= bit_reg >> 2;
                    if (bit_reg[0]) begin
                        q_reg     <= root_next[ROOT_W-1:0];
                        state_reg <= B_DINIT;
                    end
                end
                B_DINIT: begin
                    rem_reg   <= (REM_W'(msel) << FRAC_SH) + REM_W'(q_reg >> 1);
                    quo_reg   <= '0;
                    step_reg  <= 4'(QUO_W - 1);
                    state_reg <= B_DIV;
                end
                B_DIV: begin
                    if (rem_reg >= trial_div) begin
                        rem_reg <= rem_reg - trial_div;
                    end
                    quo_reg <= quo_next;
                    if (step_reg == 4'd0) begin
                        nrm_reg[comp_reg] <= neg_reg[comp_reg] ? (NRM_W'(0) - NRM_W'(quo_next))
                                                               : NRM_W'(quo_next);
                        if (comp_reg == 2'd2) begin
                            state_reg <= B_OUT;
                        end else begin
                            comp_reg  <= comp_reg + 2'd1;
                            state_reg <= B_DINIT;
                        end
                    end else begin
                        step_reg <= step_reg - 4'd1;
                    end
                end
                B_OUT: begin
                    if (res_ready) begin
                        state_reg <= B_IDLE;
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- design/polygon_newell_normal_core.sv -----
// top level of the polygon newell normal core
`default_nettype none
// Polygon normal by Newell's method. Vertices stream in on the s_ side, one
// item per vertex, s_tlast on the last vertex of each polygon. The intake
// stage takes each vertex through capture, multiply and accumulate before it
// accepts the next; the last vertex also runs the closing edge back to the
// first vertex and then hands the sums to a two-entry job queue. The
// normalizer drains that queue on its own: it scales the three sums with a
// one-bit-per-cycle shifter, forms the sum of squares on one multiplier,
// takes a bit-serial square root and runs a restoring divider for each
// component; degenerate and too-long polygons skip straight to the output.
// While the queue has room, the intake can take the next polygon even when
// the normalizer is busy. One result item per polygon leaves on the m_ side
// from an output register, so the normalizer can start the next polygon
// while a result waits. m_tuser carries the status: 0 ok, 1 zero sum, 2 more
// than MAX_POLYGON_VERTICES vertices.
module polygon_newell_normal_core
    import pnn_pkg::*;
#(
    parameter int MAX_POLYGON_VERTICES = 16,
    parameter int COORD_WIDTH          = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // vertex items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // coord_x, coord_y, coord_z, vertex_index
    input  wire logic        s_tlast,   // last_vertex
    // result items
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // normal_x, normal_y, normal_z, target_index
    output logic [1:0]       m_tuser    // status
);
    localparam int EXT_W = (COORD_WIDTH > 16) ? COORD_WIDTH : 16;

    // coordinates use only the low COORD_WIDTH bits, two's complement
    logic [EXT_W-1:0]              ext_x, ext_y, ext_z;
    logic signed [COORD_WIDTH-1:0] cx, cy, cz;

    assign ext_x = EXT_W'(s_tdata[15:0]);
    assign ext_y = EXT_W'(s_tdata[31:16]);
    assign ext_z = EXT_W'(s_tdata[47:32]);
    assign cx    = signed'(ext_x[COORD_WIDTH-1:0]);
    assign cy    = signed'(ext_y[COORD_WIDTH-1:0]);
    assign cz    = signed'(ext_z[COORD_WIDTH-1:0]);

    logic    push_valid, push_ready;
    job_t    push_job;
    logic    pop_valid, pop_ready;
    job_t    pop_job;
    logic    res_valid, res_ready;
    result_t res;

    pnn_front #(
        .MAX_VERT (MAX_POLYGON_VERTICES),
        .COORD_W  (COORD_WIDTH)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_x       (cx),
        .in_y       (cy),
        .in_z       (cz),
        .in_index   (s_tdata[63:48]),
        .in_last    (s_tlast),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    pnn_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    pnn_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_job   (pop_job),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // output register: free when empty or being taken this cycle
    logic    out_valid_reg;
    result_t out_reg;

    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_ready) begin
            out_valid_reg <= res_valid;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.target_index, out_reg.normal_z,
                       out_reg.normal_y, out_reg.normal_x};
    assign m_tuser  = out_reg.status;

endmodule
`default_nettype wire
